### hw/rtl/avx_pkg.sv
package avx_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_kind;
        logic [1:0] error_code;
        logic       sps_missing;
        logic       pps_missing;
        logic       out_last;
    } out_item_t;

    // Work handed from the parser to the emitter for one accepted input item
    typedef struct packed {
        logic       start_code;
        logic       data_byte;
        logic [7:0] byte_val;
        logic       status;
        logic [1:0] error_code;
        logic       sps_missing;
        logic       pps_missing;
    } cmd_t;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_LIMIT     = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    localparam logic       KIND_DATA   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [2:0] HEADER_SKIP    = 3'd5;
    localparam logic [7:0] SPS_COUNT_MASK = 8'h1f;
    localparam logic [2:0] START_CODE_LEN = 3'd4;
    localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

    localparam logic [30:0] LIMIT_RESET = 31'd2147483583;
    localparam int          PADDR_W     = 3;
    localparam logic        REG_LIMIT   = 1'b0;

endpackage

### hw/rtl/avx_parse.sv
module avx_parse
    import avx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_item_t    item,
    input  logic [30:0] limit,
    output logic        push,
    output cmd_t        cmd
);

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_SPSCOUNT = 3'd1,
        PH_SIZEHI   = 3'd2,
        PH_SIZELO   = 3'd3,
        PH_DATA     = 3'd4,
        PH_PPSCOUNT = 3'd5,
        PH_DONE     = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  units_reg, units_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  size_hi_reg, size_hi_next;
    logic [31:0] total_reg, total_next;
    logic [1:0]  seen_reg, seen_next;
    logic [1:0]  err_reg, err_next;
    logic        pps_grp_reg, pps_grp_next;

    logic [15:0] size_word;
    logic [31:0] sum;

    assign size_word = {size_hi_reg, item.in_byte};
    assign sum       = total_reg + {16'd0, size_word} + 32'd4;

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        units_next      = units_reg;
        bytes_left_next = bytes_left_reg;
        size_hi_next    = size_hi_reg;
        total_next      = total_reg;
        seen_next       = seen_reg;
        err_next        = err_reg;
        pps_grp_next    = pps_grp_reg;
        cmd             = '0;

        if (err_reg == ERR_NONE)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    if (hdr_cnt_next >= HEADER_SKIP)
                        phase_next = PH_SPSCOUNT;
                end
                PH_SPSCOUNT:
                begin
                    units_next = item.in_byte & SPS_COUNT_MASK;
                    if (units_next != 8'd0)
                    begin
                        seen_next[0] = 1'b1;
                        phase_next   = PH_SIZEHI;
                    end
                    else
                        phase_next = PH_PPSCOUNT;
                end
                PH_PPSCOUNT:
                begin
                    pps_grp_next = 1'b1;
                    units_next   = item.in_byte;
                    if (item.in_byte != 8'd0)
                    begin
                        seen_next[1] = 1'b1;
                        phase_next   = PH_SIZEHI;
                    end
                    else
                        phase_next = PH_DONE;
                end
                PH_SIZEHI:
                begin
                    size_hi_next = item.in_byte;
                    phase_next   = PH_SIZELO;
                end
                PH_SIZELO:
                begin
                    bytes_left_next = size_word;
                    total_next      = sum;
                    if (sum > {1'b0, limit})
                        err_next = ERR_LIMIT;
                    else
                    begin
                        cmd.start_code = 1'b1;
                        if (size_word == 16'd0)
                        begin
                            // zero-size unit: start code only, unit ends here
                            units_next = units_reg - 8'd1;
                            if (units_reg != 8'd1)
                                phase_next = PH_SIZEHI;
                            else if (!pps_grp_reg)
                                phase_next = PH_PPSCOUNT;
                            else
                                phase_next = PH_DONE;
                        end
                        else
                            phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    cmd.data_byte   = 1'b1;
                    cmd.byte_val    = item.in_byte;
                    bytes_left_next = bytes_left_reg - 16'd1;
                    if (bytes_left_reg == 16'd1)
                    begin
                        units_next = units_reg - 8'd1;
                        if (units_reg != 8'd1)
                            phase_next = PH_SIZEHI;
                        else if (!pps_grp_reg)
                            phase_next = PH_PPSCOUNT;
                        else
                            phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (item.in_last)
        begin
            cmd.status      = 1'b1;
            cmd.error_code  = err_next;
            if (err_next == ERR_NONE && phase_next < PH_DONE)
                cmd.error_code = ERR_TRUNCATED;
            cmd.sps_missing = ~seen_next[0];
            cmd.pps_missing = ~seen_next[1];
            // drop all record state so the next byte opens a new record
            phase_next      = PH_HEADER;
            hdr_cnt_next    = '0;
            units_next      = '0;
            bytes_left_next = '0;
            size_hi_next    = '0;
            total_next      = '0;
            seen_next       = '0;
            err_next        = ERR_NONE;
            pps_grp_next    = 1'b0;
        end
    end

    assign push = accept & (cmd.start_code | cmd.data_byte | cmd.status);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            hdr_cnt_reg    <= '0;
            units_reg      <= '0;
            bytes_left_reg <= '0;
            size_hi_reg    <= '0;
            total_reg      <= '0;
            seen_reg       <= '0;
            err_reg        <= ERR_NONE;
            pps_grp_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            units_reg      <= units_next;
            bytes_left_reg <= bytes_left_next;
            size_hi_reg    <= size_hi_next;
            total_reg      <= total_next;
            seen_reg       <= seen_next;
            err_reg        <= err_next;
            pps_grp_reg    <= pps_grp_next;
        end
    end

endmodule

### hw/rtl/avx_queue.sv
module avx_queue
    import avx_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### hw/rtl/avx_emit.sv
module avx_emit
    import avx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic [2:0]  sc_left_reg, sc_left_next;
    logic        dat_reg, dat_next;
    logic        stat_reg, stat_next;
    cmd_t        wk_reg, wk_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    logic        adv;
    logic        busy;
    logic [1:0]  sc_idx;

    assign adv    = ~out_valid_reg | ~out_stall;
    assign busy   = (sc_left_reg != 3'd0) | dat_reg | stat_reg;
    assign sc_idx = 2'(START_CODE_LEN - sc_left_reg);

    always_comb
    begin
        sc_left_next   = sc_left_reg;
        dat_next       = dat_reg;
        stat_next      = stat_reg;
        wk_next        = wk_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;

        if (adv)
        begin
            out_valid_next = busy;
            out_next       = '0;
            if (sc_left_reg != 3'd0)
            begin
                out_next.out_byte = START_CODE[sc_idx];
                sc_left_next      = sc_left_reg - 3'd1;
            end
            else if (dat_reg)
            begin
                out_next.out_byte = wk_reg.byte_val;
                dat_next          = 1'b0;
            end
            else if (stat_reg)
            begin
                out_next.out_kind    = KIND_STATUS;
                out_next.error_code  = wk_reg.error_code;
                out_next.sps_missing = wk_reg.sps_missing;
                out_next.pps_missing = wk_reg.pps_missing;
                out_next.out_last    = 1'b1;
                stat_next            = 1'b0;
            end
        end

        // load the next command once the current one has nothing left to send
        if (!q_empty && sc_left_next == 3'd0 && !dat_next && !stat_next)
        begin
            q_pop        = 1'b1;
            wk_next      = q_cmd;
            sc_left_next = q_cmd.start_code ? START_CODE_LEN : 3'd0;
            dat_next     = q_cmd.data_byte;
            stat_next    = q_cmd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_left_reg   <= '0;
            dat_reg       <= 1'b0;
            stat_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sc_left_reg   <= sc_left_next;
            dat_reg       <= dat_next;
            stat_reg      <= stat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wk_reg  <= wk_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### hw/rtl/avx_to_annexb_top_placeholder_unused.sv
module avx_limit_reg
    import avx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic [30:0]        limit
);

    logic [30:0] limit_reg;
    logic        reg_hit;

    assign reg_hit = (paddr[PADDR_W-1] == REG_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (psel && penable && pwrite && reg_hit)
            limit_reg <= pwdata[30:0];
    end

    always_comb
    begin
        prdata = '0;
        if (reg_hit)
            prdata = {1'b0, limit_reg};
    end

    assign limit = limit_reg;

endmodule

### hw/rtl/avcc_to_annexb_extradata.sv
// Channel   Dir   Handshake          Payload
// in        in    in_valid/in_stall   in_data   (in_item_t: record byte, last flag)
// out       out   out_valid/out_stall out_data  (out_item_t: Annex B byte or status)
// cfg       in    APB psel/penable    output_limit at byte address 0
//
// Input items are taken one per cycle while the command queue has room; the parser
// classifies each byte combinationally and queues its work.
// The emitter sends one result per cycle while out is not stalled: a unit size byte yields
// four start code bytes, a payload byte itself, and the final byte also a status item.
// Sustained rate with out unstalled is one item per cycle on payload bytes, set by the
// emitter's output register; start code bursts are absorbed by the QUEUE_DEPTH-entry queue.
// Reset is asynchronous, active low: parse state, queue and output valid clear,
// output_limit returns to 2147483583. A stall on out holds the result and, once the
// queue fills, raises in_stall.
module avcc_to_annexb_extradata
    import avx_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic        accept;
    logic        push;
    cmd_t        push_cmd;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    cmd_t        q_cmd;
    logic [30:0] limit;

    // hold input off while the queue cannot take another command
    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;
    assign pready   = 1'b1;

    avx_limit_reg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .limit   (limit)
    );

    // front: classify each record byte and advance the parse state
    avx_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .limit  (limit),
        .push   (push),
        .cmd    (push_cmd)
    );

    avx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_cmd),
        .empty    (q_empty)
    );

    // back: expand each command into start code, data and status items
    avx_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb
    import avx_pkg::*;
();

    // Cycles to let pass once nothing is pending: header bytes leave no result, so the
    // parser may still be busy after the last result has come.
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_WAIT       = 19;

    // Parser phases of the predictor
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SPS_COUNT,
        PH_SIZE_HI,
        PH_SIZE_LO,
        PH_PAYLOAD,
        PH_PPS_COUNT,
        PH_DONE
    } parse_phase_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_item_t           in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    avcc_to_annexb_extradata u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor state: a private copy of the parser and of output_limit
    logic [30:0]  cfg_limit = LIMIT_RESET;
    parse_phase_t phase;
    logic [2:0]   hdr_count;
    logic [7:0]   units_left;
    logic [15:0]  bytes_left;
    logic [7:0]   size_hi;
    logic [31:0]  out_total;
    logic         sps_found;
    logic         pps_found;
    logic [1:0]   err_latched;
    logic         in_pps_group;

    out_item_t    annexb_due[$];    // Annex B bytes and status items still to come
    logic [7:0]   record_bytes[$];  // record being built for the next send
    out_item_t    got_item;
    out_item_t    want_item;

    int  fail_count   = 0;
    int  items_sent   = 0;
    int  quiet_cycles = 0;
    int  stall_left   = 0;
    bit  idle_in      = 1'b1;
    bit  idle_out     = 1'b1;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Drop all stream state; output_limit is kept
    function automatic void clear_record_state();
        phase        = PH_HEADER;
        hdr_count    = '0;
        units_left   = '0;
        bytes_left   = '0;
        size_hi      = '0;
        out_total    = '0;
        sps_found    = 1'b0;
        pps_found    = 1'b0;
        err_latched  = ERR_NONE;
        in_pps_group = 1'b0;
    endfunction

    function automatic void queue_result(logic [7:0] b, logic kind, logic [1:0] err,
                                         logic sm, logic pm, logic last);
        out_item_t r;
        r.out_byte    = b;
        r.out_kind    = kind;
        r.error_code  = err;
        r.sps_missing = sm;
        r.pps_missing = pm;
        r.out_last    = last;
        annexb_due.push_back(r);
    endfunction

    // One unit done: next size, or on to the PPS count, or the record is complete
    function automatic void unit_done();
        units_left = units_left - 8'd1;
        if (units_left != 0)
            phase = PH_SIZE_HI;
        else if (!in_pps_group)
            phase = PH_PPS_COUNT;
        else
            phase = PH_DONE;
    endfunction

    function automatic void parse_record_byte(logic [7:0] b, logic last);
        logic [1:0] status_err;
        if (err_latched == ERR_NONE)
        begin
            case (phase)
                PH_HEADER:
                begin
                    hdr_count = hdr_count + 3'd1;
                    if (hdr_count >= HEADER_SKIP)
                        phase = PH_SPS_COUNT;
                end
                PH_SPS_COUNT:
                begin
                    units_left = b & SPS_COUNT_MASK;
                    if (units_left != 0)
                    begin
                        sps_found = 1'b1;
                        phase     = PH_SIZE_HI;
                    end
                    else
                        phase = PH_PPS_COUNT;
                end
                PH_PPS_COUNT:
                begin
                    in_pps_group = 1'b1;
                    units_left   = b;
                    if (units_left != 0)
                    begin
                        pps_found = 1'b1;
                        phase     = PH_SIZE_HI;
                    end
                    else
                        phase = PH_DONE;
                end
                PH_SIZE_HI:
                begin
                    size_hi = b;
                    phase   = PH_SIZE_LO;
                end
                PH_SIZE_LO:
                begin
                    bytes_left = {size_hi, b};
                    out_total  = out_total + 32'(bytes_left) + 32'd4;
                    // Over the limit: no start code, latch the error, ignore the rest
                    if (out_total > {1'b0, cfg_limit})
                        err_latched = ERR_LIMIT;
                    else
                    begin
                        for (int k = 0; k < 4; k++)
                            queue_result(START_CODE[k], KIND_DATA, ERR_NONE, 1'b0, 1'b0, 1'b0);
                        if (bytes_left == 0)
                            unit_done();
                        else
                            phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    queue_result(b, KIND_DATA, ERR_NONE, 1'b0, 1'b0, 1'b0);
                    bytes_left = bytes_left - 16'd1;
                    if (bytes_left == 0)
                        unit_done();
                end
                default: ;
            endcase
        end

        // Final byte: one status item, then start a fresh record
        if (last)
        begin
            status_err = err_latched;
            if (status_err == ERR_NONE && phase != PH_DONE)
                status_err = ERR_TRUNCATED;
            queue_result(8'h00, KIND_STATUS, status_err, !sps_found, !pps_found, 1'b1);
            clear_record_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall driver, result checker, watchdog
    // ------------------------------------------------------------------

    // Draw a fresh wait after every taken result; count it down otherwise
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            stall_left = idle_out ? $urandom_range(0, MAX_WAIT) : 0;
        else if (stall_left > 0)
            stall_left = stall_left - 1;
        out_stall <= (stall_left != 0);
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare every taken result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_item = out_data;
            if (annexb_due.size() == 0)
            begin
                $error("unexpected result: out_byte %0h out_kind %0b",
                       got_item.out_byte, got_item.out_kind);
                fail_count++;
            end
            else
            begin
                want_item = annexb_due.pop_front();
                check_field("out_byte", want_item.out_byte, got_item.out_byte);
                check_field("out_kind", 8'(want_item.out_kind), 8'(got_item.out_kind));
                check_field("error_code", 8'(want_item.error_code),
                            8'(got_item.error_code));
                check_field("sps_missing", 8'(want_item.sps_missing),
                            8'(got_item.sps_missing));
                check_field("pps_missing", 8'(want_item.pps_missing),
                            8'(got_item.pps_missing));
                check_field("out_last", 8'(want_item.out_last), 8'(got_item.out_last));
            end
        end
    end

    // End the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("avcc_to_annexb_extradata regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------

    // Send one record byte: optional idle gap, hold until taken, then predict
    task automatic send_item(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_in ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_record_byte(b, last);
        items_sent++;
    endtask

    // Send record_bytes up to last_at, flagging that byte as the final one
    task automatic send_record(input int last_at);
        for (int i = 0; i <= last_at; i++)
            send_item(record_bytes[i], i == last_at);
    endtask

    task automatic send_whole_record();
        send_record(record_bytes.size() - 1);
    endtask

    // Lower valid, wait for every predicted result, then let the parser settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (annexb_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Five random header bytes and an SPS count with random upper bits
    task automatic start_record(input int n_sps);
        record_bytes.delete();
        repeat (5) record_bytes.push_back(8'($urandom));
        record_bytes.push_back({3'($urandom), 5'(n_sps)});
    endtask

    task automatic add_unit(input int size);
        record_bytes.push_back(8'(size >> 8));
        record_bytes.push_back(8'(size));
        repeat (size) record_bytes.push_back(8'($urandom));
    endtask

    task automatic build_record(input int n_sps, input int n_pps, input int max_size);
        start_record(n_sps);
        repeat (n_sps) add_unit($urandom_range(0, max_size));
        record_bytes.push_back(8'(n_pps));
        repeat (n_pps) add_unit($urandom_range(0, max_size));
    endtask

    // Write output_limit only while idle, then read it back
    task automatic write_limit(input logic [30:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_LIMIT);
        pwdata  <= {1'($urandom), value};   // upper bit is not part of the register
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cfg_limit = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(value))
        begin
            $error("output_limit mismatch: expected %0h, actual %0h", 32'(value), prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, a zero-size unit, a zero SPS count and a one-byte record
    task automatic test_directed_records();
        idle_in  = 1'b1;
        idle_out = 1'b1;
        // one SPS of a single 0xFF byte, one empty PPS; count byte has upper bits set
        record_bytes = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hE1, 8'h00, 8'h01, 8'hFF,
                        8'h01, 8'h00, 8'h00};
        send_whole_record();
        // zero SPS count: the next byte is the PPS count, also zero
        record_bytes = {8'hAA, 8'h55, 8'h7F, 8'h80, 8'h01, 8'h00, 8'h00};
        send_whole_record();
        // record cut off in the header
        record_bytes = {8'h80};
        send_whole_record();
    endtask

    task automatic test_output_limit();
        // limit zero: any unit overflows, a record without units still passes
        write_limit(31'd0);
        build_record(1, 1, 4);
        send_whole_record();
        build_record(0, 0, 0);
        send_whole_record();

        // largest limit with a huge announced size: no overflow, cut short instead
        write_limit(31'h7FFF_FFFF);
        start_record(1);
        add_unit(3);
        record_bytes[6] = 8'hFF;
        send_whole_record();

        // exact boundary: SPS 6 + 4 and PPS 2 + 4 make 16 bytes
        write_limit(31'd16);
        start_record(1);
        add_unit(6);
        record_bytes.push_back(8'd1);
        add_unit(2);
        send_whole_record();
        write_limit(31'd15);
        send_whole_record();

        // small random limits, sometimes with a large size high byte
        repeat (3)
        begin
            write_limit(31'($urandom_range(0, 60)));
            repeat (2)
            begin
                build_record($urandom_range(1, 3), $urandom_range(0, 3), 8);
                if ($urandom_range(0, 1) == 1)
                    record_bytes[6] = 8'($urandom_range(1, 255));
                send_whole_record();
            end
        end
        write_limit(LIMIT_RESET);
    endtask

    // Mostly well-formed records with random content; the rest trailing bytes,
    // truncations and plain noise. Each quarter uses its own idling mix.
    task automatic test_random_records();
        int target;
        int shape;
        int n_sps;
        int n_pps;
        for (int q = 0; q < 4; q++)
        begin
            idle_in  = (q == 0 || q == 2);
            idle_out = (q == 0 || q == 3);
            target   = items_sent + 20;
            while (items_sent < target)
            begin
                shape = $urandom_range(0, 99);
                n_sps = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 31)
                                                    : $urandom_range(0, 3);
                n_pps = $urandom_range(0, 3);
                build_record(n_sps, n_pps, (n_sps > 3) ? 1 : 10);
                if (shape < 75)
                    send_whole_record();
                else if (shape < 85)
                begin
                    // trailing bytes after a complete record are ignored
                    repeat ($urandom_range(1, 3)) record_bytes.push_back(8'($urandom));
                    send_whole_record();
                end
                else if (shape < 93)
                    send_record($urandom_range(0, record_bytes.size() - 2));
                else
                begin
                    record_bytes.delete();
                    repeat ($urandom_range(1, 10)) record_bytes.push_back(8'($urandom));
                    send_whole_record();
                end
            end
        end
    endtask

    // Hold the sender after each record until every result has come
    task automatic test_drain_between_records();
        idle_in  = 1'b0;
        idle_out = 1'b1;
        repeat (4)
        begin
            build_record($urandom_range(0, 2), $urandom_range(0, 2), 6);
            send_whole_record();
            wait_idle();
        end
    endtask

    initial
    begin
        clear_record_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_records();
        test_output_limit();
        test_random_records();
        test_drain_between_records();

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("avcc_to_annexb_extradata regression: pass");
        else
            $display("avcc_to_annexb_extradata regression: fail");
        $finish;
    end

endmodule

### sim.f
hw/rtl/avx_pkg.sv
hw/rtl/avx_parse.sv
hw/rtl/avx_queue.sv
hw/rtl/avx_emit.sv
hw/rtl/avx_to_annexb_top_placeholder_unused.sv
hw/rtl/avcc_to_annexb_extradata.sv
tb/tb.sv
